@@ hw/rtl/hcnt_pkg.sv @@
// Shared types and constants for the hop count neighbour table.
// Used by hcnt_store and hop_count_neighbor_table; depends on nothing.
package hcnt_pkg;

  // Default table depth, one entry per node identifier
  localparam int NODE_COUNT_DEF = 256;

  localparam int ID_W   = 8;
  localparam int HOP_W  = 8;
  localparam int AGE_W  = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [HOP_W-1:0] HOP_MAX = {HOP_W{1'b1}};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SELF_ID = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE = 1'b1;

  localparam logic [ID_W-1:0]  SELF_ID_RST = 8'd0;
  localparam logic [AGE_W-1:0] MAX_AGE_RST = 8'd3;

  typedef enum logic [1:0] {
    CMD_HEADER = 2'd0,
    CMD_PAIR   = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SWEEP,
    ST_FETCH
  } state_t;

  // One table entry
  typedef struct packed {
    logic [HOP_W-1:0] hops;
    logic [AGE_W-1:0] age;
  } entry_t;

  // Write request into the entry store
  typedef struct packed {
    logic   en;
    entry_t data;
  } wr_req_t;

endpackage

@@ hw/rtl/hcnt_store.sv @@
// Entry store: hop count and age per node id, one write and one read a cycle.
// Per-entry valid bits make never-written entries read as zero after reset.
// Depends on hcnt_pkg.
module hcnt_store #(
  parameter int NODE_COUNT = hcnt_pkg::NODE_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [$clog2(NODE_COUNT)-1:0] rd_addr,
  output hcnt_pkg::entry_t           rd_data,
  input  hcnt_pkg::wr_req_t          wr_req,
  input  logic [$clog2(NODE_COUNT)-1:0] wr_addr
);

  hcnt_pkg::entry_t          entry_mem [NODE_COUNT];
  logic [NODE_COUNT-1:0]     valid_r;
  hcnt_pkg::entry_t          rd_raw_r;
  logic                      rd_valid_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      entry_mem[wr_addr] <= wr_req.data;
    end
  end

  // Mark written entries; reset empties the whole table at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_req.en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // Registered read port, hold data between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_raw_r   <= entry_mem[rd_addr];
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  // Entries never written read as zero (dead)
  assign rd_data = rd_valid_r ? rd_raw_r : '0;

endmodule

@@ hw/rtl/hop_count_neighbor_table.sv @@
// Hop count neighbour table: distance-vector hop counts with age counters.
// Header, route pair and read: an accepted item goes through the store's registered
// read and then the lookup state, which loads the result register once the output
// can take it; no new item is taken until then. Age tick: one entry decremented per
// cycle by the sweep. Reset (synchronous, active low) clears all table valid bits at
// once, so the block is ready straight after reset; self_id resets to 0, max_age to 3.
module hop_count_neighbor_table #(
  parameter int NODE_COUNT = hcnt_pkg::NODE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] node_id, [15:8] hops
  input  logic [1:0]  in_tuser,   // [1:0] command
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [0] updated, [8:1] entry_hops, [9] entry_live,
                                  // [17:10] entry_age, [23:18] zero
  // configuration write port
  input  logic                          cfg_wr_en,
  input  logic [hcnt_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [7:0]                    cfg_wr_data
);

  localparam int IDX_W = $clog2(NODE_COUNT);
  localparam int CNT_W = $clog2(NODE_COUNT + 1);
  localparam logic [hcnt_pkg::ID_W:0] ID_LIMIT = (hcnt_pkg::ID_W + 1)'(NODE_COUNT);
  localparam logic [CNT_W-1:0]        CNT_END  = CNT_W'(NODE_COUNT);

  hcnt_pkg::state_t state_r, state_nxt;
  hcnt_pkg::cmd_t   cmd_r, cmd_nxt;
  logic [hcnt_pkg::ID_W-1:0]  id_r, id_nxt;
  logic [hcnt_pkg::HOP_W-1:0] hops_r, hops_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       packet_open_r, packet_open_nxt;
  logic [hcnt_pkg::ID_W-1:0]  self_id_r;
  logic [hcnt_pkg::AGE_W-1:0] max_age_r;

  logic                       out_valid_r, out_valid_nxt;
  logic                       out_upd_r, out_upd_nxt;
  logic                       out_live_r, out_live_nxt;
  hcnt_pkg::entry_t           out_entry_r, out_entry_nxt;

  logic                       rd_en;
  logic [IDX_W-1:0]           rd_addr;
  hcnt_pkg::entry_t           rd_data;
  hcnt_pkg::wr_req_t          wr_req;
  logic [IDX_W-1:0]           wr_addr;

  logic                       in_acc;
  logic                       commit;
  logic                       in_range;
  logic                       not_self;
  logic [hcnt_pkg::HOP_W-1:0] new_hops;
  logic                       pair_better;
  logic [CNT_W-1:0]           cnt_m1;

  hcnt_store #(
    .NODE_COUNT(NODE_COUNT)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_req  (wr_req),
    .wr_addr (wr_addr)
  );

  // Handshake and compare / increment / decrement logic
  assign in_tready   = (state_r == hcnt_pkg::ST_IDLE);
  assign in_acc      = in_tvalid && in_tready;
  assign commit      = !out_valid_r || out_tready;
  assign in_range    = {1'b0, id_r} < ID_LIMIT;
  assign not_self    = (id_r != self_id_r);
  assign new_hops    = (hops_r == hcnt_pkg::HOP_MAX) ? hcnt_pkg::HOP_MAX
                                                     : hops_r + 8'd1;
  assign pair_better = (rd_data.age == '0) || (rd_data.hops >= new_hops);
  assign cnt_m1      = cnt_r - CNT_W'(1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hcnt_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (hcnt_pkg::cmd_t'(in_tuser) == hcnt_pkg::CMD_TICK) ?
                      hcnt_pkg::ST_SWEEP : hcnt_pkg::ST_LOOKUP;
        end
      end
      hcnt_pkg::ST_SWEEP: begin
        if (cnt_r == CNT_END) begin
          state_nxt = hcnt_pkg::ST_FETCH;
        end
      end
      hcnt_pkg::ST_FETCH: begin
        state_nxt = hcnt_pkg::ST_LOOKUP;
      end
      hcnt_pkg::ST_LOOKUP: begin
        if (commit) begin
          state_nxt = hcnt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hcnt_pkg::ST_IDLE;
    endcase
  end

  // Datapath control and result formation
  always_comb begin
    cmd_nxt         = cmd_r;
    id_nxt          = id_r;
    hops_nxt        = hops_r;
    cnt_nxt         = cnt_r;
    packet_open_nxt = packet_open_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_upd_nxt     = out_upd_r;
    out_live_nxt    = out_live_r;
    out_entry_nxt   = out_entry_r;
    rd_en           = 1'b0;
    rd_addr         = id_r[IDX_W-1:0];
    wr_req          = '0;
    wr_addr         = id_r[IDX_W-1:0];

    unique case (state_r)
      hcnt_pkg::ST_IDLE: begin
        // Latch the request and look up its entry
        if (in_acc) begin
          cmd_nxt  = hcnt_pkg::cmd_t'(in_tuser);
          id_nxt   = in_tdata[7:0];
          hops_nxt = in_tdata[15:8];
          cnt_nxt  = '0;
          rd_en    = 1'b1;
          rd_addr  = in_tdata[IDX_W-1:0];
        end
      end
      hcnt_pkg::ST_SWEEP: begin
        // Read entry cnt, write back the decremented age of entry cnt-1
        if (cnt_r != CNT_END) begin
          rd_en   = 1'b1;
          rd_addr = cnt_r[IDX_W-1:0];
        end
        if (cnt_r != '0 && rd_data.age != '0) begin
          wr_req.en         = 1'b1;
          wr_req.data.hops  = rd_data.hops;
          wr_req.data.age   = rd_data.age - 8'd1;
          wr_addr           = cnt_m1[IDX_W-1:0];
        end
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      hcnt_pkg::ST_FETCH: begin
        // Re-read the addressed entry once the sweep has finished
        rd_en = 1'b1;
      end
      hcnt_pkg::ST_LOOKUP: begin
        if (commit) begin
          out_valid_nxt = 1'b1;
          out_upd_nxt   = 1'b0;
          out_entry_nxt = rd_data;
          case (cmd_r)
            hcnt_pkg::CMD_HEADER: begin
              packet_open_nxt = not_self;
              if (not_self && in_range) begin
                wr_req.en = 1'b1;
              end
              wr_req.data.hops = 8'd1;
            end
            hcnt_pkg::CMD_PAIR: begin
              if (packet_open_r && not_self && in_range && pair_better) begin
                wr_req.en = 1'b1;
              end
              wr_req.data.hops = new_hops;
            end
            default: begin
              wr_req.data.hops = rd_data.hops;
            end
          endcase
          wr_req.data.age = max_age_r;
          if (wr_req.en) begin
            out_upd_nxt   = 1'b1;
            out_entry_nxt = wr_req.data;
          end
          // Identifiers beyond the table report zero
          if (!in_range) begin
            out_entry_nxt = '0;
          end
          out_live_nxt = (out_entry_nxt.age != '0);
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= hcnt_pkg::ST_IDLE;
      packet_open_r <= 1'b0;
      out_valid_r   <= 1'b0;
      cnt_r         <= '0;
    end else begin
      state_r       <= state_nxt;
      packet_open_r <= packet_open_nxt;
      out_valid_r   <= out_valid_nxt;
      cnt_r         <= cnt_nxt;
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    id_r        <= id_nxt;
    hops_r      <= hops_nxt;
    out_upd_r   <= out_upd_nxt;
    out_live_r  <= out_live_nxt;
    out_entry_r <= out_entry_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_id_r <= hcnt_pkg::SELF_ID_RST;
      max_age_r <= hcnt_pkg::MAX_AGE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        hcnt_pkg::REG_SELF_ID: self_id_r <= cfg_wr_data;
        hcnt_pkg::REG_MAX_AGE: max_age_r <= cfg_wr_data;
        default: self_id_r <= self_id_r;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_entry_r.age, out_live_r, out_entry_r.hops, out_upd_r};

  // The store is never written while waiting for a request
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hcnt_pkg::ST_IDLE) |-> !wr_req.en)
    else $error("store written while idle");

  // The sweep counter never runs past the table end
  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hcnt_pkg::ST_SWEEP) |-> (cnt_r <= CNT_END))
    else $error("sweep counter overrun");

  // A sweep always ends with a re-read of the addressed entry
  a_sweep_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hcnt_pkg::ST_SWEEP && cnt_r == CNT_END) |=>
    (state_r == hcnt_pkg::ST_FETCH))
    else $error("sweep did not hand over to fetch");

  // A commit loads the result register and returns the block to idle
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hcnt_pkg::ST_LOOKUP && commit) |=>
    (out_valid_r && state_r == hcnt_pkg::ST_IDLE))
    else $error("result not loaded on commit");

  // An entry written by a request always carries a non-zero hop count
  a_upd_hops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_upd_r) |-> (out_entry_r.hops != '0))
    else $error("updated entry with zero hops");

endmodule
